// ===== src/b64kd_pkg.sv =====
// Shared constants, types and the character map of the base64url key decoder.
package b64kd_pkg;

    localparam int CHAR_COUNT = 87;
    localparam int KEY_BYTES  = 65;

    localparam int CHARS_W = 10;
    localparam int INDEX_W = 7;
    localparam int STORE_W = 12;
    localparam int PEND_W  = 4;

    localparam logic [CHARS_W-1:0] CHARS_MAX    = {CHARS_W{1'b1}};
    localparam logic [CHARS_W:0]   CHARS_TARGET = (CHARS_W+1)'(CHAR_COUNT);
    localparam logic [INDEX_W-1:0] BYTES_LIMIT  = INDEX_W'(KEY_BYTES);
    localparam logic [7:0]         PREFIX_BYTE  = 8'h04;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_LENGTH   = 3'd1,
        ST_CHAR     = 3'd2,
        ST_OVERFLOW = 3'd3,
        ST_LEFTOVER = 3'd4,
        ST_PREFIX   = 3'd5
    } status_t;

    typedef struct packed {
        logic       ok;
        logic [5:0] value;
    } sextet_t;

    // Six-bit value of a base64url character; ok is low outside the alphabet.
    function automatic sextet_t sextet_of(input logic [7:0] c);
        sextet_t s;
        s.ok    = 1'b1;
        s.value = 6'd0;
        if (c >= 8'h41 && c <= 8'h5a)
        begin
            s.value = 6'(c - 8'h41);
        end
        else if (c >= 8'h61 && c <= 8'h7a)
        begin
            s.value = 6'(c - 8'h61 + 8'd26);
        end
        else if (c >= 8'h30 && c <= 8'h39)
        begin
            s.value = 6'(c - 8'h30 + 8'd52);
        end
        else if (c == 8'h2d)
        begin
            s.value = 6'd62;
        end
        else if (c == 8'h5f)
        begin
            s.value = 6'd63;
        end
        else
        begin
            s.ok = 1'b0;
        end
        return s;
    endfunction

endpackage

// ===== src/base64url_key_decoder_unit.sv =====
// Base64url key decoder: one text character in, one result item out per character.
//
// Takes an unpadded base64url text (A-Z a-z 0-9 - _) one character per input item,
// with tlast on the final character. Every character adds six bits to a 12-bit
// accumulator; each time a byte completes it leaves on the output item with its
// index (tuser high). The item for the final character carries tlast and a status:
// 0 ok, 1 bad length, 2 bad character, 3 too many bytes, 4 leftover bits nonzero,
// 5 first byte not 04. The first error sticks (later characters are only counted),
// but a wrong character count always reports bad length. All state clears after
// the final character, ready for the next key. Every input item yields exactly
// one output item, registered on acceptance. Decoding is a single pass of table
// lookup, shift and counter updates into the output register, so one item is taken
// every cycle while the output side accepts; the input is held off only while the
// output register is full and not being taken.
module base64url_key_decoder_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] char_code
    input  logic        s_axis_tlast,   // last_char
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,   // [7:0] data_byte, [14:8] byte_index,
                                        // [17:15] status, [23:18] zero
    output logic        m_axis_tuser,   // byte_valid
    output logic        m_axis_tlast    // done_res
);

    // decoder state
    logic [b64kd_pkg::STORE_W-1:0] store_reg,   store_next;
    logic [b64kd_pkg::PEND_W-1:0]  pend_reg,    pend_next;
    logic [b64kd_pkg::CHARS_W-1:0] chars_reg,   chars_next;
    logic [b64kd_pkg::INDEX_W-1:0] bytes_reg,   bytes_next;
    b64kd_pkg::status_t            err_reg,     err_next;
    logic                          prefix_reg,  prefix_next;

    // output register
    logic                          ovalid_reg;
    logic                          bvalid_reg,  bvalid_next;
    logic [7:0]                    data_reg,    data_next;
    logic [b64kd_pkg::INDEX_W-1:0] index_reg,   index_next;
    logic                          done_reg;
    b64kd_pkg::status_t            status_reg,  status_next;

    logic                          in_accept;
    b64kd_pkg::sextet_t            sx;
    logic [b64kd_pkg::STORE_W-1:0] store_upd;
    logic [b64kd_pkg::PEND_W-1:0]  pend_sum;
    logic [b64kd_pkg::PEND_W-1:0]  pend_left;
    logic [b64kd_pkg::STORE_W-1:0] shifted;

    assign s_axis_tready = !ovalid_reg || m_axis_tready;
    assign in_accept     = s_axis_tvalid && s_axis_tready;

    assign sx        = b64kd_pkg::sextet_of(s_axis_tdata);
    assign store_upd = {store_reg[b64kd_pkg::STORE_W-7:0], sx.value};
    assign pend_sum  = pend_reg + b64kd_pkg::PEND_W'(6);
    assign pend_left = pend_sum - b64kd_pkg::PEND_W'(8);
    assign shifted   = store_upd >> pend_left;

    always_comb
    begin
        store_next  = store_reg;
        pend_next   = pend_reg;
        bytes_next  = bytes_reg;
        err_next    = err_reg;
        prefix_next = prefix_reg;
        bvalid_next = 1'b0;
        data_next   = 8'd0;
        index_next  = '0;
        status_next = b64kd_pkg::ST_OK;
        chars_next  = chars_reg;

        // accumulate while no error is recorded
        if (err_reg == b64kd_pkg::ST_OK)
        begin
            if (!sx.ok)
            begin
                err_next = b64kd_pkg::ST_CHAR;
            end
            else
            begin
                store_next = store_upd;
                pend_next  = pend_sum;
                if (pend_sum >= b64kd_pkg::PEND_W'(8))
                begin
                    pend_next = pend_left;
                    if (bytes_reg >= b64kd_pkg::BYTES_LIMIT)
                    begin
                        err_next = b64kd_pkg::ST_OVERFLOW;
                    end
                    else
                    begin
                        bvalid_next = 1'b1;
                        data_next   = shifted[7:0];
                        index_next  = bytes_reg;
                        if (bytes_reg == '0)
                        begin
                            prefix_next = (shifted[7:0] == b64kd_pkg::PREFIX_BYTE);
                        end
                        bytes_next = bytes_reg + b64kd_pkg::INDEX_W'(1);
                    end
                end
            end
        end

        if (s_axis_tlast)
        begin
            // length mismatch outranks any recorded error
            if (({1'b0, chars_reg} + 11'd1) != b64kd_pkg::CHARS_TARGET)
            begin
                status_next = b64kd_pkg::ST_LENGTH;
            end
            else if (err_next != b64kd_pkg::ST_OK)
            begin
                status_next = err_next;
            end
            else if (bytes_next != b64kd_pkg::BYTES_LIMIT
                     || pend_next != b64kd_pkg::PEND_W'(2))
            begin
                status_next = b64kd_pkg::ST_LENGTH;
            end
            else if (store_next[1:0] != 2'b00)
            begin
                status_next = b64kd_pkg::ST_LEFTOVER;
            end
            else if (!prefix_next)
            begin
                status_next = b64kd_pkg::ST_PREFIX;
            end
            else
            begin
                status_next = b64kd_pkg::ST_OK;
            end
            // clear for the next key
            store_next  = '0;
            pend_next   = '0;
            chars_next  = '0;
            bytes_next  = '0;
            err_next    = b64kd_pkg::ST_OK;
            prefix_next = 1'b0;
        end
        else if (chars_reg != b64kd_pkg::CHARS_MAX)
        begin
            chars_next = chars_reg + b64kd_pkg::CHARS_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            store_reg  <= '0;
            pend_reg   <= '0;
            chars_reg  <= '0;
            bytes_reg  <= '0;
            err_reg    <= b64kd_pkg::ST_OK;
            prefix_reg <= 1'b0;
            ovalid_reg <= 1'b0;
            bvalid_reg <= 1'b0;
            done_reg   <= 1'b0;
            status_reg <= b64kd_pkg::ST_OK;
        end
        else
        begin
            if (in_accept)
            begin
                store_reg  <= store_next;
                pend_reg   <= pend_next;
                chars_reg  <= chars_next;
                bytes_reg  <= bytes_next;
                err_reg    <= err_next;
                prefix_reg <= prefix_next;
                ovalid_reg <= 1'b1;
                bvalid_reg <= bvalid_next;
                done_reg   <= s_axis_tlast;
                status_reg <= status_next;
            end
            else if (m_axis_tready)
            begin
                ovalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            data_reg  <= data_next;
            index_reg <= index_next;
        end
    end

    assign m_axis_tvalid = ovalid_reg;
    assign m_axis_tuser  = bvalid_reg;
    assign m_axis_tlast  = done_reg;
    assign m_axis_tdata  = {6'd0, status_reg, index_reg, data_reg};

    // checks
    a_pend_even: assert property (@(posedge clk) disable iff (!rst_n)
        pend_reg[0] == 1'b0 && pend_reg <= b64kd_pkg::PEND_W'(6))
        else $error("pending bit count out of range");

    a_status_only_done: assert property (@(posedge clk) disable iff (!rst_n)
        ovalid_reg && !done_reg |-> status_reg == b64kd_pkg::ST_OK)
        else $error("status on non-final item");

    a_no_byte_data: assert property (@(posedge clk) disable iff (!rst_n)
        ovalid_reg && !bvalid_reg |-> data_reg == 8'd0 && index_reg == '0)
        else $error("byte data without byte_valid");

    a_err_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        in_accept && !s_axis_tlast && err_reg != b64kd_pkg::ST_OK
        |=> $stable(err_reg) && $stable(bytes_reg) && $stable(store_reg))
        else $error("decoder state moved after an error");

    a_bytes_bound: assert property (@(posedge clk) disable iff (!rst_n)
        bytes_reg <= b64kd_pkg::BYTES_LIMIT)
        else $error("byte count beyond key length");

endmodule
